// ===== rtl/imu_serial_frame_parser_core_macros.svh =====
// Assertion macros for the IMU serial frame parser.
`ifndef IMU_SERIAL_FRAME_PARSER_CORE_MACROS_SVH
`define IMU_SERIAL_FRAME_PARSER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IMUSFP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("imusfp same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define IMUSFP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("imusfp next-cycle check failed");

`endif

// ===== rtl/imusfp_pkg.sv =====
// Shared types, constants and codes of the IMU serial frame parser.
`default_nettype none

package imusfp_pkg;

   localparam int FRAME_LEN  = 11;
   localparam int CELL_COUNT = FRAME_LEN - 1;
   localparam int DECODE_LEN = 8;
   localparam int FILL_W     = $clog2(FRAME_LEN);

   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAME_LEN - 1);

   localparam logic [7:0] SYNC_RESET = 8'h55;
   localparam logic [7:0] TYPE_MASK  = 8'h50;
   localparam logic [7:0] TYPE_ACCEL = 8'h51;
   localparam logic [7:0] TYPE_GYRO  = 8'h52;
   localparam logic [7:0] TYPE_ANGLE = 8'h53;
   localparam logic [7:0] TYPE_MAG   = 8'h54;

   typedef logic [7:0] octet_type;

   // Bytes 0..7 of a full window: header, type and the three data words.
   typedef logic [DECODE_LEN-1:0][7:0] window_type;

   typedef enum logic [2:0] {
      KIND_ACCEL   = 3'd0,
      KIND_GYRO    = 3'd1,
      KIND_ANGLE   = 3'd2,
      KIND_MAG     = 3'd3,
      KIND_UNKNOWN = 3'd4,
      KIND_HDR_ERR = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [7:0]         type_byte;
      logic signed [31:0] x_value;
      logic signed [31:0] y_value;
      logic signed [31:0] z_value;
   } result_type;

   typedef struct packed {
      logic out_valid;
      logic skid_valid;
   } buf_status_type;

endpackage

`default_nettype wire

// ===== rtl/imusfp_cell.sv =====
// One byte cell of the receive shift window.
`default_nettype none

module imusfp_cell
   import imusfp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      shift_en,
   input  wire octet_type shift_in,
   output      octet_type data_out
);

   octet_type data_ff;
   octet_type data_in;

   always_comb begin
      data_in = shift_en ? shift_in : data_ff;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

// ===== rtl/imusfp_decode.sv =====
// Header check and Q16.16 scaling of one full frame window.
`default_nettype none

module imusfp_decode
   import imusfp_pkg::*;
(
   input  wire logic [7:0] sync_byte,
   input  wire window_type window,
   output      logic       header_ok,
   output      result_type result
);

   logic [7:0]         type_byte;
   logic signed [15:0] word_x;
   logic signed [15:0] word_y;
   logic signed [15:0] word_z;
   logic signed [31:0] ext_x;
   logic signed [31:0] ext_y;
   logic signed [31:0] ext_z;

   assign type_byte = window[1];
   assign header_ok = (window[0] == sync_byte) && ((type_byte & TYPE_MASK) == TYPE_MASK);

   // Little-endian signed words start at byte 2.
   assign word_x = {window[3], window[2]};
   assign word_y = {window[5], window[4]};
   assign word_z = {window[7], window[6]};
   assign ext_x  = 32'(word_x);
   assign ext_y  = 32'(word_y);
   assign ext_z  = 32'(word_z);

   always_comb begin
      result.type_byte = type_byte;
      result.kind      = KIND_HDR_ERR;
      result.x_value   = '0;
      result.y_value   = '0;
      result.z_value   = '0;
      if (header_ok) begin
         case (type_byte)
            TYPE_ACCEL: begin
               result.kind    = KIND_ACCEL;
               result.x_value = ext_x <<< 5;
               result.y_value = ext_y <<< 5;
               result.z_value = ext_z <<< 5;
            end
            TYPE_GYRO: begin
               result.kind    = KIND_GYRO;
               result.x_value = 32'(ext_x * 32'sd4000);
               result.y_value = 32'(ext_y * 32'sd4000);
               result.z_value = 32'(ext_z * 32'sd4000);
            end
            TYPE_ANGLE: begin
               result.kind    = KIND_ANGLE;
               result.x_value = 32'(ext_x * 32'sd360);
               result.y_value = 32'(ext_y * 32'sd360);
               result.z_value = 32'(ext_z * 32'sd360);
            end
            TYPE_MAG: begin
               result.kind    = KIND_MAG;
               result.x_value = ext_x <<< 16;
               result.y_value = ext_y <<< 16;
               result.z_value = ext_z <<< 16;
            end
            default: begin
               result.kind = KIND_UNKNOWN;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/imusfp_outbuf.sv =====
// Result register with a skid stage behind it.
`default_nettype none

module imusfp_outbuf
   import imusfp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire result_type push_data,
   input  wire logic       out_stall,
   output      result_type out_data,
   output      buf_status_type status
);

   logic       out_valid_ff;
   logic       out_valid_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   result_type out_data_ff;
   result_type out_data_in;
   result_type skid_data_ff;
   result_type skid_data_in;
   logic       pop;

   assign pop = out_valid_ff && !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            // A push cannot coincide with a full skid stage.
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_data          = out_data_ff;
   assign status.out_valid  = out_valid_ff;
   assign status.skid_valid = skid_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/imu_serial_frame_parser_core.sv =====
// Top level of the IMU serial frame parser: byte cell chain, decoder and result buffer.
// Throughput: one received byte per cycle unless the input stalls. A byte completing an
// 11-byte window registers its result in the result register, or in its skid stage if
// that register is held. The input stalls only while both the result register and its
// skid stage are occupied. Synchronous active-high reset empties the window count and
// the result buffer and sets the sync byte to 0x55; window bytes are not cleared.
`default_nettype none

`include "imu_serial_frame_parser_core_macros.svh"

module imu_serial_frame_parser_core
   import imusfp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // Configuration port: the sync byte.
   input  wire logic               csr_wr_en,
   input  wire logic [7:0]         csr_wr_data,
   // Received byte channel.
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [7:0]         req_rx_byte,
   // Result channel.
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [2:0]         rsp_frame_kind,
   output      logic [7:0]         rsp_type_byte,
   output      logic signed [31:0] rsp_x_value,
   output      logic signed [31:0] rsp_y_value,
   output      logic signed [31:0] rsp_z_value
);

   // Sync byte register; the user is to write it only while the block is idle, which the block itself does not enforce.
   logic [7:0] sync_ff;
   logic [7:0] sync_in;

   // Number of bytes currently held in the window, 0..10.
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;

   logic           accept;
   logic           frame_done;
   logic           header_ok;
   window_type     window;
   result_type     decoded;
   result_type     rsp_data;
   buf_status_type buf_status;
   octet_type      cell_data [CELL_COUNT];

   assign accept = req_valid && !req_stall;

   // The window is full when the incoming byte lands on top of ten held bytes.
   assign frame_done = accept && (fill_ff == FILL_FULL);

   // The chain of byte cells. Every accepted byte shifts the whole chain by one
   // place toward cell 0, so the most recent ten bytes always sit in cells 0..9
   // in arrival order. The fill count says how many of them belong to the window;
   // dropping the oldest byte on a bad header therefore needs no data movement,
   // only the count stays at ten, and emptying the window only clears the count.
   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      octet_type shift_in;
      if (i == CELL_COUNT - 1) begin : g_tail
         assign shift_in = req_rx_byte;
      end else begin : g_link
         assign shift_in = cell_data[i+1];
      end
      imusfp_cell u_cell (
         .clock    (clock),
         .shift_en (accept),
         .shift_in (shift_in),
         .data_out (cell_data[i])
      );
   end

   // Window bytes 0..7 are the oldest eight held bytes when the window completes;
   // bytes 8..10 (fourth word and checksum) are never examined.
   for (genvar j = 0; j < DECODE_LEN; j++) begin : g_window
      assign window[j] = cell_data[j];
   end

   imusfp_decode u_decode (
      .sync_byte (sync_ff),
      .window    (window),
      .header_ok (header_ok),
      .result    (decoded)
   );

   // A good header empties the window; a bad one drops the oldest byte and
   // keeps ten, so each following byte rechecks a full window.
   always_comb begin
      fill_in = fill_ff;
      if (frame_done) begin
         fill_in = header_ok ? '0 : FILL_FULL;
      end else if (accept) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_comb begin
      sync_in = csr_wr_en ? csr_wr_data : sync_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         sync_ff <= SYNC_RESET;
      end else begin
         fill_ff <= fill_in;
         sync_ff <= sync_in;
      end
   end

   // Result register plus skid stage: a byte is still taken while a finished
   // result waits, and the input stalls only once the skid stage is also full.
   imusfp_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_done),
      .push_data (decoded),
      .out_stall (rsp_stall),
      .out_data  (rsp_data),
      .status    (buf_status)
   );

   assign req_stall      = buf_status.skid_valid;
   assign rsp_valid      = buf_status.out_valid;
   assign rsp_frame_kind = rsp_data.kind;
   assign rsp_type_byte  = rsp_data.type_byte;
   assign rsp_x_value    = rsp_data.x_value;
   assign rsp_y_value    = rsp_data.y_value;
   assign rsp_z_value    = rsp_data.z_value;

   // Window count never passes ten held bytes.
   `IMUSFP_ASSERT_NOW(a_fill_range, 1'b1, fill_ff <= FILL_FULL)
   // A byte that does not complete the window only advances the count.
   `IMUSFP_ASSERT_NEXT(a_fill_step, accept && (fill_ff != FILL_FULL), fill_ff == FILL_W'($past(fill_ff) + 1'b1))
   // A rejected header keeps ten bytes and leaves a result behind.
   `IMUSFP_ASSERT_NEXT(a_hdr_reject, frame_done && !header_ok, (fill_ff == FILL_FULL) && rsp_valid)
   // The skid stage only fills behind an occupied result register.
   `IMUSFP_ASSERT_NOW(a_skid_order, buf_status.skid_valid, buf_status.out_valid)

endmodule

`default_nettype wire

// ===== tb/tb_imu_serial_frame_parser_core.sv =====
// Self-checking testbench for the IMU serial frame parser core.
`timescale 1ns / 100ps

module tb_imu_serial_frame_parser_core
   import imusfp_pkg::*;
();

   // The frame tracker mirrors the parser's byte window and sync register. Every accepted
   // item is pushed through the same window rules, and each window that yields a result
   // leaves one expected result in a queue. Results from the block are compared in order.
   class frame_scoreboard;
      octet_type    window[FRAME_LEN];
      int unsigned  fill;
      octet_type    sync_value;
      result_type   expected_q[$];
      int unsigned  mismatches;

      function new();
         fill       = 0;
         sync_value = SYNC_RESET;
         mismatches = 0;
      endfunction

      function void set_sync(octet_type value);
         sync_value = value;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // One little-endian 16-bit word of the window, scaled to Q16.16 and cut to 32 bits.
      function logic signed [31:0] scaled_axis(int unsigned pos, longint factor);
         logic signed [15:0] raw;
         longint             product;
         raw     = {window[pos + 1], window[pos]};
         product = longint'(raw) * factor;
         return 32'(product);
      endfunction

      // Notes one accepted item and queues the result it causes, if any.
      function void note_byte(octet_type rx);
         result_type  res;
         octet_type   type_value;
         longint      factor;
         int unsigned i;
         window[fill] = rx;
         fill++;
         if (fill < FRAME_LEN) return;
         type_value    = window[1];
         res           = '0;
         res.type_byte = type_value;
         if (window[0] != sync_value || (type_value & TYPE_MASK) != TYPE_MASK) begin
            // Bad header: slide the window by one byte and recheck on the next item.
            for (i = 0; i < FRAME_LEN - 1; i++) window[i] = window[i + 1];
            fill     = FRAME_LEN - 1;
            res.kind = KIND_HDR_ERR;
         end else begin
            case (type_value)
               TYPE_ACCEL: begin
                  res.kind = KIND_ACCEL;
                  factor   = 32;
               end
               TYPE_GYRO: begin
                  res.kind = KIND_GYRO;
                  factor   = 4000;
               end
               TYPE_ANGLE: begin
                  res.kind = KIND_ANGLE;
                  factor   = 360;
               end
               TYPE_MAG: begin
                  res.kind = KIND_MAG;
                  factor   = 65536;
               end
               default: begin
                  res.kind = KIND_UNKNOWN;
                  factor   = 0;
               end
            endcase
            res.x_value = scaled_axis(2, factor);
            res.y_value = scaled_axis(4, factor);
            res.z_value = scaled_axis(6, factor);
            fill        = 0;
         end
         expected_q.push_back(res);
      endfunction

      // Compares one accepted result with the oldest expectation, field by field.
      function void check_result(logic [2:0] kind, logic [7:0] type_byte,
                                 logic signed [31:0] x_value, logic signed [31:0] y_value,
                                 logic signed [31:0] z_value);
         result_type exp_res;
         if (expected_q.size() == 0) begin
            $error("unexpected result: frame_kind %0d type_byte %02h", kind, type_byte);
            mismatches++;
            return;
         end
         exp_res = expected_q.pop_front();
         if (kind !== exp_res.kind) begin
            $error("frame_kind: expected %0d, actual %0d", exp_res.kind, kind);
            mismatches++;
         end
         if (type_byte !== exp_res.type_byte) begin
            $error("type_byte: expected %02h, actual %02h", exp_res.type_byte, type_byte);
            mismatches++;
         end
         if (x_value !== exp_res.x_value) begin
            $error("x_value: expected %0d, actual %0d", exp_res.x_value, x_value);
            mismatches++;
         end
         if (y_value !== exp_res.y_value) begin
            $error("y_value: expected %0d, actual %0d", exp_res.y_value, y_value);
            mismatches++;
         end
         if (z_value !== exp_res.z_value) begin
            $error("z_value: expected %0d, actual %0d", exp_res.z_value, z_value);
            mismatches++;
         end
      endfunction
   endclass

   // All inputs of the block start at known values before the first edge.
   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               csr_wr_en   = 1'b0;
   logic [7:0]         csr_wr_data = 8'h00;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   logic [2:0]         rsp_frame_kind;
   logic [7:0]         rsp_type_byte;
   logic signed [31:0] rsp_x_value;
   logic signed [31:0] rsp_y_value;
   logic signed [31:0] rsp_z_value;

   frame_scoreboard frames = new();

   // Idle rates in percent, set by the stimulus as it moves from phase to phase.
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   // The stimulus bumps hold_request to ask for a long receiver hold-off; the receiver
   // process notices the change and counts the stretch down on its own.
   int unsigned hold_request = 0;
   int unsigned hold_seen    = 0;
   int unsigned hold_left    = 0;

   // Sync byte that the well-formed frames of the current phase start with.
   octet_type frame_sync = SYNC_RESET;

   imu_serial_frame_parser_core u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_type_byte  (rsp_type_byte),
      .rsp_x_value    (rsp_x_value),
      .rsp_y_value    (rsp_y_value),
      .rsp_z_value    (rsp_z_value)
   );

   always #1 clock = ~clock;

   // Receiver: random stalls, or a long solid hold-off when one has been requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Result monitor. Outputs are read at the edge, before the block updates them.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         frames.check_result(rsp_frame_kind, rsp_type_byte, rsp_x_value, rsp_y_value,
                             rsp_z_value);
   end

   // Offers one item, possibly after idling first, and returns once it is accepted.
   // Valid stays high from one item to the next when no idle cycle falls between them.
   task automatic send_byte(octet_type rx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      frames.note_byte(rx);
   endtask

   // Data words favor the signed extremes, since those expose overflow and sign errors.
   function automatic logic [15:0] random_word();
      case ($urandom_range(7))
         0:       return 16'h0000;
         1:       return 16'h7FFF;
         2:       return 16'h8000;
         3:       return 16'hFFFF;
         default: return 16'($urandom_range(16'hFFFF));
      endcase
   endfunction

   // One full 11-byte frame: header, type, three words, then the unused word and checksum.
   task automatic send_frame(octet_type header, octet_type type_value, logic [15:0] w0,
                             logic [15:0] w1, logic [15:0] w2);
      send_byte(header);
      send_byte(type_value);
      send_byte(w0[7:0]);
      send_byte(w0[15:8]);
      send_byte(w1[7:0]);
      send_byte(w1[15:8]);
      send_byte(w2[7:0]);
      send_byte(w2[15:8]);
      repeat (3) send_byte(8'($urandom_range(255)));
   endtask

   // Drops valid and waits until every expected result has come back, then lets the
   // block settle in case the last item left work in flight.
   task automatic drain_results();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames.pending() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   // Writes the sync register; the caller has already let the block go idle.
   task automatic write_sync(octet_type value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      frames.set_sync(value);
      frame_sync = value;
   endtask

   // Random traffic: mostly well-formed frames with random content, plus bursts of
   // noise and truncated frames that push the parser into header recovery.
   task automatic send_random_traffic(int unsigned byte_budget);
      int unsigned sent;
      int unsigned pick;
      int unsigned count;
      octet_type   type_value;
      sent = 0;
      while (sent < byte_budget) begin
         pick = $urandom_range(99);
         if ($urandom_range(99) < 70)
            type_value = 8'(TYPE_ACCEL + $urandom_range(3));
         else if ($urandom_range(1) == 0)
            type_value = 8'($urandom_range(255)) | TYPE_MASK;
         else
            type_value = 8'($urandom_range(255));
         if (pick < 75) begin
            send_frame(frame_sync, type_value, random_word(), random_word(), random_word());
            sent += FRAME_LEN;
         end else if (pick < 88) begin
            count = $urandom_range(6, 1);
            repeat (count) send_byte(8'($urandom_range(255)));
            sent += count;
         end else begin
            count = $urandom_range(8);
            send_byte(frame_sync);
            send_byte(type_value);
            repeat (count) send_byte(8'($urandom_range(255)));
            sent += count + 2;
         end
      end
   endtask

   // Idles, writes a new sync byte and runs one stretch of random traffic.
   task automatic run_setting(octet_type sync_value, int unsigned byte_budget);
      drain_results();
      write_sync(sync_value);
      send_random_traffic(byte_budget);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // First phase: the sender idles now and then, the receiver stalls most cycles.
      send_idle_pct  = 32;
      recv_stall_pct = 87;

      // Directed frames under the reset sync byte: every frame type with extreme words,
      // unknown types that still pass the header mask, a wrong sync byte, a type byte
      // that fails the mask, and a clean frame that has to resynchronize afterwards.
      // The first ten bytes also cover the case of a window that is not yet full.
      send_frame(SYNC_RESET, TYPE_ACCEL, 16'h7FFF, 16'h8000, 16'h0000);
      send_frame(SYNC_RESET, TYPE_GYRO,  16'hFFFF, 16'h0001, 16'h7FFF);
      send_frame(SYNC_RESET, TYPE_ANGLE, 16'h8000, 16'h7FFF, 16'hFFFF);
      send_frame(SYNC_RESET, TYPE_MAG,   16'h7FFF, 16'h8000, 16'h0001);
      send_frame(SYNC_RESET, 8'h50, random_word(), random_word(), random_word());
      send_frame(SYNC_RESET, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_frame(8'hAA, TYPE_ACCEL, random_word(), random_word(), random_word());
      send_frame(SYNC_RESET, 8'h41, random_word(), random_word(), random_word());
      send_frame(SYNC_RESET, TYPE_GYRO, 16'h8000, 16'h0000, 16'h7FFF);

      // Long receiver hold-off while the sender keeps offering noise. Once the window is
      // full every byte yields a result, so the result buffer fills and the input
      // must stall until the receiver lets go.
      drain_results();
      hold_request++;
      repeat (40) send_byte(8'($urandom_range(255)));

      run_setting(SYNC_RESET, 250);
      run_setting(8'h00, 250);

      // Second phase: the sender is sparse and the receiver rarely stalls.
      send_idle_pct  = 87;
      recv_stall_pct = 32;
      run_setting(8'hFF, 250);
      run_setting(8'($urandom_range(255)), 250);

      // Last phase: back-to-back traffic with no idling on either side.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_setting(8'($urandom_range(255)), 250);
      run_setting(SYNC_RESET, 250);

      drain_results();
      if (frames.pending() != 0) begin
         $error("%0d expected results never arrived", frames.pending());
         frames.mismatches++;
      end
      if (frames.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      #1000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/imusfp_pkg.sv
rtl/imusfp_cell.sv
rtl/imusfp_decode.sv
rtl/imusfp_outbuf.sv
rtl/imu_serial_frame_parser_core.sv
tb/tb_imu_serial_frame_parser_core.sv
